// ===== sv/smb_pkg.sv =====
// shared types, widths and constants of the softmax uncertainty mask blend unit
package smb_pkg;

   localparam int LOGIT_W    = 16;
   localparam int MAX_PIXELS = 65536;
   localparam int IDX_W      = $clog2(MAX_PIXELS);
   localparam int FRAME_W    = 17;
   localparam int D_W        = 15;
   localparam int P_W        = 11;
   localparam int L_W        = 15;
   localparam int D_LIMIT    = 8192;
   localparam int P_ONE      = 1024;

   localparam int DIV_BITS   = 17;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int SIG_LAT    = 4 + DIV_STAGES + 1;
   localparam int LOG_STEPS  = 10;
   localparam int LOG_LAT    = LOG_STEPS + 1;
   localparam int LAT        = SIG_LAT + LOG_LAT + 3;

   localparam int TQ_DEPTH   = 4;
   localparam int TQ_AW      = $clog2(TQ_DEPTH);
   localparam int OUT_DEPTH  = 32;
   localparam int OUT_AW     = $clog2(OUT_DEPTH);

   localparam logic CSR_USE_PREV_MSK = 1'b0;
   localparam logic CSR_FRAME_PIXELS = 1'b1;

   typedef struct packed {
      logic                      blend;
      logic                      prev_valid;
      logic                      last;
      logic [IDX_W-1:0]          idx;
      logic signed [LOGIT_W-1:0] bg;
      logic signed [D_W-1:0]     d;
   } task_type;

   typedef struct packed {
      logic                      blend;
      logic                      prev_valid;
      logic                      last;
      logic [IDX_W-1:0]          idx;
      logic signed [LOGIT_W-1:0] bg;
      logic [P_W-1:0]            p;
   } side_type;

   typedef struct packed {
      logic signed [LOGIT_W-1:0] mask_value;
      logic                      frame_end;
   } rsp_type;

endpackage

// ===== sv/smb_front.sv =====
// front end: csr, pixel counter, item classification and task queue
module smb_front import smb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic                      csr_index,
   input  logic [FRAME_W-1:0]        csr_wdata,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic signed [LOGIT_W-1:0] req_bg_logit,
   input  logic signed [LOGIT_W-1:0] req_fg_logit,
   input  logic                      task_pop,
   output logic                      task_empty,
   output task_type                  task_head
);

   logic               use_prev_ff;
   logic [FRAME_W-1:0] frame_pixels_ff;
   logic [IDX_W-1:0]   pixel_ff, pixel_in;
   logic               prev_valid_ff, prev_valid_in;

   task_type           tq_ff [TQ_DEPTH];
   logic [TQ_AW-1:0]   tq_wr_ff, tq_rd_ff;
   logic [TQ_AW:0]     tq_cnt_ff;

   logic               accept;
   logic [FRAME_W-1:0] size;
   logic               last;
   logic signed [LOGIT_W:0] diff;
   task_type           new_task;

   assign req_full   = (tq_cnt_ff == (TQ_AW+1)'(TQ_DEPTH));
   assign task_empty = (tq_cnt_ff == '0);
   assign task_head  = tq_ff[tq_rd_ff];
   assign accept     = req_push && !req_full;

   always_comb begin
      if (frame_pixels_ff == '0) begin
         size = FRAME_W'(1);
      end else if (frame_pixels_ff > FRAME_W'(MAX_PIXELS)) begin
         size = FRAME_W'(MAX_PIXELS);
      end else begin
         size = frame_pixels_ff;
      end
      last = (FRAME_W'(pixel_ff) + FRAME_W'(1)) >= size;
      diff = (LOGIT_W+1)'(req_bg_logit) - (LOGIT_W+1)'(req_fg_logit);
      new_task.blend      = use_prev_ff;
      new_task.prev_valid = prev_valid_ff;
      new_task.last       = last;
      new_task.idx        = pixel_ff;
      new_task.bg         = req_bg_logit;
      if (diff > (LOGIT_W+1)'(D_LIMIT)) begin
         new_task.d = D_W'(D_LIMIT);
      end else if (diff < -(LOGIT_W+1)'(D_LIMIT)) begin
         new_task.d = -D_W'(D_LIMIT);
      end else begin
         new_task.d = D_W'(diff);
      end
      pixel_in      = last ? '0 : pixel_ff + IDX_W'(1);
      prev_valid_in = prev_valid_ff || (use_prev_ff && last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_prev_ff     <= 1'b0;
         frame_pixels_ff <= FRAME_W'(MAX_PIXELS);
         pixel_ff        <= '0;
         prev_valid_ff   <= 1'b0;
         tq_wr_ff        <= '0;
         tq_rd_ff        <= '0;
         tq_cnt_ff       <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_USE_PREV_MSK: use_prev_ff     <= csr_wdata[0];
               CSR_FRAME_PIXELS: frame_pixels_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            pixel_ff      <= pixel_in;
            prev_valid_ff <= prev_valid_in;
            tq_wr_ff      <= tq_wr_ff + TQ_AW'(1);
         end
         if (task_pop) begin
            tq_rd_ff <= tq_rd_ff + TQ_AW'(1);
         end
         tq_cnt_ff <= tq_cnt_ff + (TQ_AW+1)'(accept) - (TQ_AW+1)'(task_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tq_ff[tq_wr_ff] <= new_task;
      end
   end

endmodule

// ===== sv/smb_sigmoid.sv =====
// pipelined sigmoid of the clamped logit difference, Q1.10 result
module smb_sigmoid import smb_pkg::*; (
   input  logic                  clock,
   input  logic signed [D_W-1:0] d,
   output logic [P_W-1:0]        p
);

   logic [13:0] t_ff;
   logic        neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [3:0]  n2_ff, n3_ff;
   logic [15:0] u2_ff, u3_ff;
   logic [13:0] s1_ff;
   logic [15:0] s2_ff;
   logic [17:0] den4_ff;

   logic [17:0] r_ff   [DIV_STAGES];
   logic [16:0] q_ff   [DIV_STAGES];
   logic [17:0] den_ff [DIV_STAGES];
   logic        neg_ff [DIV_STAGES];
   logic [P_W-1:0] p_ff;

   logic [13:0] ad;
   logic [24:0] tprod;
   logic [27:0] m1;
   logic [29:0] m2;
   logic [31:0] m3;
   logic [16:0] v;

   always_comb begin
      ad    = d[D_W-1] ? 14'(-d) : 14'(d);
      tprod = 25'(ad) * 25'(1477) + 25'(512);
      m1    = 28'(t_ff[9:0]) * 28'(3638) <<< 6;
      m2    = 30'(u2_ff) * 30'(s1_ff);
      m3    = 32'(u3_ff) * 32'(s2_ff);
      v     = 17'(65536) - 17'(m3 >> 16);
   end

   always_ff @(posedge clock) begin
      t_ff    <= 14'(tprod >> 10);
      neg1_ff <= d[D_W-1];
      n2_ff   <= t_ff[13:10];
      u2_ff   <= {t_ff[9:0], 6'b0};
      s1_ff   <= 14'(15743) - 14'(m1 >> 16);
      neg2_ff <= neg1_ff;
      n3_ff   <= n2_ff;
      u3_ff   <= u2_ff;
      s2_ff   <= 16'(45426) - 16'(m2 >> 16);
      neg3_ff <= neg2_ff;
      den4_ff <= 18'(65536) + 18'(v >> n3_ff);
      neg4_ff <= neg3_ff;
   end

   // restoring divide of 2^32 by den, up to DIV_STEPS quotient bits per stage
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [17:0] r_src, r_in;
      logic [16:0] q_src, q_in;
      logic [17:0] den_src;
      logic        neg_src;
      if (k == 0) begin : g_first
         assign r_src   = 18'(32768);
         assign q_src   = '0;
         assign den_src = den4_ff;
         assign neg_src = neg4_ff;
      end else begin : g_next
         assign r_src   = r_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign den_src = den_ff[k-1];
         assign neg_src = neg_ff[k-1];
      end
      always_comb begin
         r_in = r_src;
         q_in = q_src;
         for (int j = 0; j < DIV_STEPS; j++) begin
            if (k * DIV_STEPS + j < DIV_BITS) begin
               r_in = r_in << 1;
               q_in = q_in << 1;
               if (r_in >= den_src) begin
                  r_in    = r_in - den_src;
                  q_in[0] = 1'b1;
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         r_ff[k]   <= r_in;
         q_ff[k]   <= q_in;
         den_ff[k] <= den_src;
         neg_ff[k] <= neg_src;
      end
   end

   logic [16:0] p16;
   assign p16 = neg_ff[DIV_STAGES-1] ? 17'(65536) - q_ff[DIV_STAGES-1]
                                     : q_ff[DIV_STAGES-1];

   always_ff @(posedge clock) begin
      p_ff <= P_W'((p16 + 17'(32)) >> 6);
   end

   assign p = p_ff;

endmodule

// ===== sv/smb_log2.sv =====
// pipelined log2 of (p << 6) + eps, signed Q.10, one squaring per stage
module smb_log2 import smb_pkg::*; (
   input  logic                  clock,
   input  logic [P_W-1:0]        p,
   output logic signed [L_W-1:0] l
);

   logic [15:0]      y_ff    [LOG_STEPS+1];
   logic [9:0]       frac_ff [LOG_STEPS+1];
   logic signed [4:0] ip_ff  [LOG_STEPS+1];

   logic [16:0] x;
   logic [4:0]  m;
   logic [15:0] y0;

   always_comb begin
      x = {p, 6'b0} + 17'(66);
      m = '0;
      for (int i = 0; i < 17; i++) begin
         if (x[i]) begin
            m = 5'(i);
         end
      end
      if (m >= 5'd15) begin
         y0 = 16'(x >> (m - 5'd15));
      end else begin
         y0 = 16'(x << (5'd15 - m));
      end
   end

   always_ff @(posedge clock) begin
      y_ff[0]    <= y0;
      frac_ff[0] <= '0;
      ip_ff[0]   <= 5'($signed({1'b0, m}) - 6'sd16);
   end

   for (genvar k = 0; k < LOG_STEPS; k++) begin : g_sq
      logic [31:0] sq;
      logic [16:0] z;
      assign sq = 32'(y_ff[k]) * 32'(y_ff[k]);
      assign z  = 17'(sq >> 15);
      always_ff @(posedge clock) begin
         y_ff[k+1]    <= z[16] ? z[16:1] : z[15:0];
         frac_ff[k+1] <= {frac_ff[k][8:0], z[16]};
         ip_ff[k+1]   <= ip_ff[k];
      end
   end

   assign l = {ip_ff[LOG_STEPS], frac_ff[LOG_STEPS]};

endmodule

// ===== sv/smb_back.sv =====
// back end: probability, confidence, temporal mix, per-pixel store, result queue
module smb_back import smb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      task_empty,
   input  task_type                  task_head,
   output logic                      task_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic signed [LOGIT_W-1:0] rsp_mask_value,
   output logic                      rsp_frame_end
);

   localparam int T1 = SIG_LAT + LOG_LAT;

   logic        valid_ff [LAT];
   side_type    side_ff  [LAT];
   logic [OUT_AW:0] owed_ff;

   logic [P_W-1:0]        sig_p;
   logic signed [L_W-1:0] l1, l2;

   logic signed [26:0] pr1_ff, pr2_ff;
   logic [P_W-1:0]     a_ff, a2_ff;

   logic [P_W-1:0] prev_mem [MAX_PIXELS];
   logic [P_W-1:0] rdata_ff, fwd_data_ff;
   logic           fwd_ff;

   rsp_type         oq_ff [OUT_DEPTH];
   logic [OUT_AW-1:0] oq_wr_ff, oq_rd_ff;
   logic [OUT_AW:0] oq_cnt_ff;

   logic           issue, push, wen, take;
   logic [IDX_W-1:0] waddr;
   logic [P_W-1:0] prev, wdata;
   logic signed [27:0] term, tsum;
   logic [17:0]    ash;
   logic [P_W-1:0] a_in, a2_in;
   logic [22:0]    a2_prod;
   logic [23:0]    mix;
   logic signed [LOGIT_W-1:0] result;
   side_type       fin;
   side_type       sig_side;

   // credit covers everything in flight plus the result queue
   assign issue     = !task_empty && (owed_ff < (OUT_AW+1)'(OUT_DEPTH));
   assign task_pop  = issue;
   assign take      = rsp_pop && !rsp_empty;
   assign rsp_empty = (oq_cnt_ff == '0);
   assign rsp_mask_value = oq_ff[oq_rd_ff].mask_value;
   assign rsp_frame_end  = oq_ff[oq_rd_ff].frame_end;

   smb_sigmoid u_sigmoid (
      .clock (clock),
      .d     (task_head.d),
      .p     (sig_p)
   );

   smb_log2 u_log_p (
      .clock (clock),
      .p     (sig_p),
      .l     (l1)
   );

   smb_log2 u_log_q (
      .clock (clock),
      .p     (P_W'(P_ONE) - sig_p),
      .l     (l2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= issue;
         for (int k = 1; k < LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // the word leaving the sigmoid picks up its probability
   always_comb begin
      sig_side   = side_ff[SIG_LAT-1];
      sig_side.p = sig_p;
   end

   always_ff @(posedge clock) begin
      side_ff[0].blend      <= task_head.blend;
      side_ff[0].prev_valid <= task_head.prev_valid;
      side_ff[0].last       <= task_head.last;
      side_ff[0].idx        <= task_head.idx;
      side_ff[0].bg         <= task_head.bg;
      side_ff[0].p          <= '0;
      for (int k = 1; k < LAT; k++) begin
         side_ff[k] <= (k == SIG_LAT) ? sig_side : side_ff[k-1];
      end
   end

   always_comb begin
      term = 28'sd1048576 + 28'(pr1_ff) + 28'(pr2_ff);
      tsum = term + 28'sd512;
      ash  = 18'(tsum >>> 10);
      if (term <= 28'sd0) begin
         a_in = '0;
      end else if (ash > 18'(P_ONE)) begin
         a_in = P_W'(P_ONE);
      end else begin
         a_in = P_W'(ash);
      end
      a2_prod = 23'(a_ff) * (23'(2048) - 23'(a_ff)) + 23'(512);
      a2_in   = P_W'(a2_prod >> 10);
   end

   always_ff @(posedge clock) begin
      pr1_ff <= 27'($signed({1'b0, side_ff[T1-1].p})) * 27'(l1);
      pr2_ff <= 27'($signed({1'b0, P_W'(P_ONE) - side_ff[T1-1].p})) * 27'(l2);
      a_ff   <= a_in;
      a2_ff  <= a2_in;
   end

   always_comb begin
      fin   = side_ff[LAT-1];
      push  = valid_ff[LAT-1];
      prev  = fwd_ff ? fwd_data_ff : rdata_ff;
      mix   = (24'(fin.p) * 24'(a2_ff) + 24'(prev) * (24'(P_ONE) - 24'(a2_ff))
               + 24'(512)) >> 10;
      if (!fin.blend) begin
         result = fin.bg;
      end else if (!fin.prev_valid) begin
         result = LOGIT_W'(fin.p);
      end else begin
         result = LOGIT_W'(mix);
      end
      wen   = push && fin.blend;
      waddr = fin.idx;
      wdata = P_W'(result);
   end

   // read one stage ahead; a write to the same pixel at that edge is forwarded
   always_ff @(posedge clock) begin
      if (wen) begin
         prev_mem[waddr] <= wdata;
      end
      rdata_ff    <= prev_mem[side_ff[LAT-2].idx];
      fwd_ff      <= wen && (waddr == side_ff[LAT-2].idx);
      fwd_data_ff <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff   <= '0;
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         owed_ff <= owed_ff + (OUT_AW+1)'(issue) - (OUT_AW+1)'(take);
         if (push) begin
            oq_wr_ff <= oq_wr_ff + OUT_AW'(1);
         end
         if (take) begin
            oq_rd_ff <= oq_rd_ff + OUT_AW'(1);
         end
         oq_cnt_ff <= oq_cnt_ff + (OUT_AW+1)'(push) - (OUT_AW+1)'(take);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         oq_ff[oq_wr_ff].mask_value <= result;
         oq_ff[oq_wr_ff].frame_end  <= fin.last;
      end
   end

endmodule

// ===== sv/softmax_uncertainty_mask_blend_unit.sv =====
// top level of the softmax uncertainty mask blend unit
//
//   port group   direction   handshake          word
//   req_*        in          push / full        bg_logit, fg_logit
//   rsp_*        out         empty / pop        mask_value, frame_end
//   csr_*        in          wen, no wait       index, wdata
//
// one pixel per clock while result credit lasts; from push to rsp_empty low a word
// passes the sigmoid divider stages, the ten log2 squaring stages and the mix stage.
// reset sets csr to its defaults and clears the pixel counter, previous-frame flag and
// both queues; the per-pixel store is not cleared. the front stalls (full) only when
// its 4-word task queue fills, which happens when the 32-word result credit runs out.
module softmax_uncertainty_mask_blend_unit import smb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic                      csr_index,
   input  logic [FRAME_W-1:0]        csr_wdata,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic signed [LOGIT_W-1:0] req_bg_logit,
   input  logic signed [LOGIT_W-1:0] req_fg_logit,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic signed [LOGIT_W-1:0] rsp_mask_value,
   output logic                      rsp_frame_end
);

   task_type task_head;
   logic     task_empty, task_pop;

   smb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_bg_logit (req_bg_logit),
      .req_fg_logit (req_fg_logit),
      .task_pop     (task_pop),
      .task_empty   (task_empty),
      .task_head    (task_head)
   );

   smb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .task_empty     (task_empty),
      .task_head      (task_head),
      .task_pop       (task_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_mask_value (rsp_mask_value),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

// ===== sim/softmax_uncertainty_mask_blend_unit_tb.sv =====
// testbench of the softmax uncertainty mask blend unit: directed table, then random phases
module softmax_uncertainty_mask_blend_unit_tb import smb_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_ITEMS  = 800;
   localparam int DIR_ROWS    = 23;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wen = 1'b0;
   logic                      csr_index = CSR_USE_PREV_MSK;
   logic [FRAME_W-1:0]        csr_wdata = '0;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic signed [LOGIT_W-1:0] req_bg_logit = '0;
   logic signed [LOGIT_W-1:0] req_fg_logit = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic signed [LOGIT_W-1:0] rsp_mask_value;
   logic                      rsp_frame_end;

   softmax_uncertainty_mask_blend_unit u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic                 blend_mode = 1'b0;
   logic [FRAME_W-1:0]   frame_size = FRAME_W'(MAX_PIXELS);
   int unsigned          pix_idx = 0;
   logic                 prev_valid = 1'b0;
   logic [P_W-1:0]       prev_store [MAX_PIXELS];
   bit                   written [MAX_PIXELS];
   int                   written_run = 0;

   rsp_type pending_masks [$];
   int errors = 0;
   int cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int hold_left = 0;

   typedef struct packed {
      logic                      blend;
      logic [FRAME_W-1:0]        size;
      logic signed [LOGIT_W-1:0] bg;
      logic signed [LOGIT_W-1:0] fg;
      logic                      chk;
      logic signed [LOGIT_W-1:0] mask;
      logic                      fend;
   } dir_row_type;

   dir_row_type dir_tab [DIR_ROWS] = '{
      '{1'b0, 17'd65536, 16'sh7FFF, 16'sh0000, 1'b1, 16'sh7FFF, 1'b0},
      '{1'b0, 17'd65536, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 1'b0},
      '{1'b0, 17'd65536, 16'sh0000, 16'sh8000, 1'b1, 16'sh0000, 1'b0},
      '{1'b0, 17'd65536, 16'shFFFF, 16'shFFFF, 1'b1, 16'shFFFF, 1'b0},
      // size zero acts as one: every word ends a frame
      '{1'b0, 17'd0,     16'sh0005, 16'sh1234, 1'b1, 16'sh0005, 1'b1},
      '{1'b0, 17'd131071,16'sh5555, 16'shAAAA, 1'b1, 16'sh5555, 1'b0},
      // index already past the last pixel ends the frame
      '{1'b0, 17'd1,     16'shAAAA, 16'sh5555, 1'b1, 16'shAAAA, 1'b1},
      // first blend frame, no previous frame: output is p
      '{1'b1, 17'd16,    16'sh7FFF, 16'sh8000, 1'b1, 16'sh0400, 1'b0},
      '{1'b1, 17'd16,    16'sh8000, 16'sh7FFF, 1'b1, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh0123, 16'sh0123, 1'b1, 16'sh0200, 1'b0},
      '{1'b1, 17'd16,    16'sh2000, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh0000, 16'sh2000, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh0400, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh0000, 16'sh0400, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh0001, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh0000, 16'sh0001, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh1FFF, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh0000, 16'sh1FFF, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh0C00, 16'sh0100, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh0100, 16'sh0C00, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh0800, 16'shF800, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'shF800, 16'sh0800, 1'b0, 16'sh0000, 1'b0},
      '{1'b1, 17'd16,    16'sh0050, 16'sh0000, 1'b0, 16'sh0000, 1'b1}
   };

   function automatic int unsigned bg_prob(input int d);
      int unsigned ad, t, n, u, s, v, e, p16;
      if (d > D_LIMIT) d = D_LIMIT;
      if (d < -D_LIMIT) d = -D_LIMIT;
      ad = (d < 0) ? -d : d;
      t = (ad * 1477 + 512) >> 10;
      n = t >> 10;
      u = (t & 1023) << 6;
      s = 15743 - ((u * 3638) >> 16);
      s = 45426 - ((u * s) >> 16);
      v = 65536 - ((u * s) >> 16);
      e = (n < 32) ? (v >> n) : 0;
      s = 32'(64'h1_0000_0000 / longint'(65536 + e));
      p16 = (d >= 0) ? s : 65536 - s;
      return (p16 + 32) >> 6;
   endfunction

   function automatic int log2_fix(input int unsigned x);
      int m;
      int unsigned y, frac;
      m = 0;
      frac = 0;
      while (m < 31 && (x >> (m + 1)) != 0) m++;
      y = (m >= 15) ? (x >> (m - 15)) : (x << (15 - m));
      for (int i = 0; i < 10; i++) begin
         y = (y * y) >> 15;
         frac = frac << 1;
         if (y >= 65536) begin
            frac = frac | 1;
            y = y >> 1;
         end
      end
      return (m - 16) * 1024 + int'(frac);
   endfunction

   task automatic blend_pixel(input logic signed [LOGIT_W-1:0] bg,
                              input logic signed [LOGIT_W-1:0] fg, output rsp_type r);
      int unsigned size, idx, p, prev, a, res;
      int l1, l2, term;
      logic last;
      size = frame_size;
      if (size == 0) size = 1;
      if (size > MAX_PIXELS) size = MAX_PIXELS;
      last = (pix_idx + 1 >= size);
      idx = (pix_idx >= MAX_PIXELS) ? MAX_PIXELS - 1 : pix_idx;
      if (!blend_mode) begin
         res = 32'(bg) & 16'hFFFF;
      end else begin
         p = bg_prob(int'(bg) - int'(fg));
         res = p;
         if (prev_valid) begin
            prev = prev_store[idx];
            l1 = log2_fix((p << 6) + 66);
            l2 = log2_fix(((P_ONE - p) << 6) + 66);
            term = (1 << 20) + int'(p) * l1 + int'(P_ONE - p) * l2;
            if (term <= 0) a = 0;
            else begin
               a = (term + 512) >> 10;
               if (a > P_ONE) a = P_ONE;
            end
            a = (a * (2048 - a) + 512) >> 10;
            res = (p * a + prev * (P_ONE - a) + 512) >> 10;
         end
         prev_store[idx] = P_W'(res);
         written[idx] = 1'b1;
         while (written_run < MAX_PIXELS && written[written_run]) written_run++;
         if (last) prev_valid = 1'b1;
      end
      pix_idx = last ? 0 : pix_idx + 1;
      r.mask_value = LOGIT_W'(res);
      r.frame_end = last;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // offer one word, return once the block has taken it; push stays high afterwards
   task automatic send_word(input logic signed [LOGIT_W-1:0] bg,
                            input logic signed [LOGIT_W-1:0] fg,
                            input logic typed, input rsp_type want);
      rsp_type r;
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_bg_logit <= bg;
      req_fg_logit <= fg;
      @(posedge clock);
      while (req_full) @(posedge clock);
      blend_pixel(bg, fg, r);
      pending_masks.push_back(typed ? want : r);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (pending_masks.size() != 0) @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
   endtask

   task automatic set_regs(input logic mode, input logic [FRAME_W-1:0] size);
      csr_wen <= 1'b1;
      csr_index <= CSR_USE_PREV_MSK;
      csr_wdata <= FRAME_W'(mode);
      @(posedge clock);
      csr_index <= CSR_FRAME_PIXELS;
      csr_wdata <= size;
      @(posedge clock);
      csr_wen <= 1'b0;
      blend_mode = mode;
      frame_size = size;
   endtask

   // result side
   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_masks.size() == 0) begin
               report_mismatch("word with nothing pending, mask", rsp_mask_value, 0);
            end else begin
               w = pending_masks.pop_front();
               if (rsp_mask_value !== w.mask_value)
                  report_mismatch("mask_value", rsp_mask_value, w.mask_value);
               if (rsp_frame_end !== w.frame_end)
                  report_mismatch("frame_end", rsp_frame_end, w.frame_end);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int sent, plen, r;
      logic mode;
      logic [FRAME_W-1:0] size;
      logic signed [LOGIT_W-1:0] bg, fg;
      rsp_type none;
      bit held;
      none = '0;
      held = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_tab[i].blend != blend_mode || dir_tab[i].size != frame_size) begin
            drain();
            set_regs(dir_tab[i].blend, dir_tab[i].size);
         end
         send_word(dir_tab[i].bg, dir_tab[i].fg, dir_tab[i].chk,
                   '{mask_value: dir_tab[i].mask, frame_end: dir_tab[i].fend});
      end
      drain();

      for (int stage = 0; stage < 3; stage++) begin
         send_idle = (stage == 0) ? 11 : (stage == 1) ? 62 : 0;
         recv_idle = (stage == 0) ? 62 : (stage == 1) ? 11 : 0;
         sent = 0;
         while (sent < RAND_ITEMS / 3) begin
            mode = $urandom_range(1);
            // bring the pixel counter back to a written entry before blending
            if (mode && prev_valid && !written[pix_idx]) begin
               set_regs(1'b0, 17'd1);
               send_word(16'(LOGIT_W'($urandom)), 16'(LOGIT_W'($urandom)), 1'b0, none);
               drain();
               sent++;
            end
            r = $urandom_range(9);
            if (mode && prev_valid)
               size = (r == 0) ? 17'd0 : FRAME_W'($urandom_range(1,
                      (written_run < 64) ? written_run : 64));
            else if (r == 0)
               case ($urandom_range(3))
                  0: size = 17'd0;
                  1: size = 17'd1;
                  2: size = 17'd65536;
                  default: size = 17'd131071;
               endcase
            else
               size = FRAME_W'($urandom_range(1, 48));
            set_regs(mode, size);
            plen = $urandom_range(10, 40);
            // long receiver hold while a long burst keeps pushing, so the block fills
            if (stage == 2 && !held) begin
               hold_left = 300;
               plen = 60;
               held = 1'b1;
            end
            for (int k = 0; k < plen; k++) begin
               if (blend_mode && prev_valid &&
                   !written[(pix_idx >= MAX_PIXELS) ? MAX_PIXELS - 1 : pix_idx]) break;
               bg = LOGIT_W'($urandom);
               if ($urandom_range(3) == 0) fg = LOGIT_W'($urandom);
               else fg = bg + LOGIT_W'($urandom_range(0, 6000)) - 16'sd3000;
               send_word(bg, fg, 1'b0, none);
               sent++;
            end
            drain();
         end
      end

      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// ===== files.f =====
sv/smb_pkg.sv
sv/smb_front.sv
sv/smb_sigmoid.sv
sv/smb_log2.sv
sv/smb_back.sv
sv/softmax_uncertainty_mask_blend_unit.sv
sim/softmax_uncertainty_mask_blend_unit_tb.sv
